// ----- hdl/prt_pkg.sv -----
// ----------------------------------------------------------------------------
// prt_pkg
// Types, constants and helpers shared by the polygon ray-crossing tester.
// ----------------------------------------------------------------------------
package prt_pkg;

   localparam int COORD_W    = 16;
   localparam int BX_W       = COORD_W + 1;
   localparam int DIFF_W     = COORD_W + 2;
   localparam int PROD_W     = 2 * DIFF_W;
   localparam int ORIENT_W   = PROD_W + 1;
   localparam int COUNT_W    = 7;
   localparam int COUNT_MAX  = 127;
   localparam int FRAC_ONE   = 16;
   localparam int DRAIN_W    = 3;
   localparam logic [DRAIN_W-1:0] DRAIN_LAST = 3'd4;

   typedef enum logic [1:0] {
      OP_LOAD   = 2'd0,
      OP_CROSS  = 2'd1,
      OP_INSIDE = 2'd2
   } prt_op_type;

   typedef struct packed {
      logic [1:0]                req_type;
      logic signed [COORD_W-1:0] x0;
      logic signed [COORD_W-1:0] y0;
      logic signed [COORD_W-1:0] x1;
      logic signed [COORD_W-1:0] y1;
      logic                      restart;
      logic                      stop_at_first;
   } prt_req_type;

   typedef struct packed {
      logic [COUNT_W-1:0] crossing_count;
      logic               inside_res;
   } prt_rsp_type;

   typedef struct packed {
      logic signed [COORD_W-1:0] x;
      logic signed [COORD_W-1:0] y;
   } prt_vtx_type;

   typedef struct packed {
      logic wr_en;
      logic wr_first;
      logic query_start;
      logic query_inside;
      logic setup;
      logic rd_en;
      logic rd_first;
      logic rsp_load;
   } prt_cmd_type;

   function automatic logic prt_opposite(input logic signed [ORIENT_W-1:0] s,
                                         input logic signed [ORIENT_W-1:0] t);
      logic s_pos;
      logic t_pos;
      s_pos = !s[ORIENT_W-1] && (s != '0);
      t_pos = !t[ORIENT_W-1] && (t != '0);
      return (s[ORIENT_W-1] && t_pos) || (s_pos && t[ORIENT_W-1]);
   endfunction

endpackage

// ----- hdl/prt_ctrl.sv -----
// ----------------------------------------------------------------------------
// prt_ctrl
// Request sequencer: vertex loads, edge walk over the store, pipeline drain
// and response slot.
// ----------------------------------------------------------------------------
module prt_ctrl #(
   parameter  int MAX_VERTICES = 64,
   localparam int AW = $clog2(MAX_VERTICES),
   localparam int CW = $clog2(MAX_VERTICES + 1)
) (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  req_valid,
   output logic                  req_ready,
   input  prt_pkg::prt_req_type  req_data,
   output logic                  rsp_valid,
   input  logic                  rsp_ready,
   output prt_pkg::prt_cmd_type  cmd,
   output logic [AW-1:0]         wr_addr,
   output logic [AW-1:0]         rd_addr
);
   import prt_pkg::*;

   typedef enum logic [1:0] {
      ST_IDLE,
      ST_SETUP,
      ST_RUN,
      ST_DRAIN
   } state_type;

   state_type            state_ff, state_in;
   logic [CW-1:0]        vcount_ff, vcount_in;
   logic [CW-1:0]        rd_idx_ff, rd_idx_in;
   logic [DRAIN_W-1:0]   drain_ff, drain_in;
   logic                 rsp_valid_ff, rsp_valid_in;
   logic [CW-1:0]        eff_count;

   assign req_ready = (state_ff == ST_IDLE);
   assign rsp_valid = rsp_valid_ff;
   assign eff_count = req_data.restart ? '0 : vcount_ff;
   assign wr_addr   = eff_count[AW-1:0];
   assign rd_addr   = (rd_idx_ff == vcount_ff) ? '0 : rd_idx_ff[AW-1:0];

   always_comb begin
      state_in     = state_ff;
      vcount_in    = vcount_ff;
      rd_idx_in    = rd_idx_ff;
      drain_in     = drain_ff;
      rsp_valid_in = rsp_valid_ff && !rsp_ready;
      cmd          = '0;
      case (state_ff)
         ST_IDLE: begin
            if (req_valid) begin
               case (req_data.req_type)
                  OP_LOAD: begin
                     if (eff_count < CW'(MAX_VERTICES)) begin
                        cmd.wr_en    = 1'b1;
                        cmd.wr_first = (eff_count == '0);
                        vcount_in    = eff_count + 1'b1;
                     end
                  end
                  OP_CROSS, OP_INSIDE: begin
                     cmd.query_start  = 1'b1;
                     cmd.query_inside = (req_data.req_type == OP_INSIDE);
                     state_in         = ST_SETUP;
                  end
                  default: ;
               endcase
            end
         end
         ST_SETUP: begin
            cmd.setup = 1'b1;
            rd_idx_in = '0;
            drain_in  = '0;
            state_in  = (vcount_ff == '0) ? ST_DRAIN : ST_RUN;
         end
         ST_RUN: begin
            cmd.rd_en    = 1'b1;
            cmd.rd_first = (rd_idx_ff == '0);
            if (rd_idx_ff == vcount_ff) begin
               state_in = ST_DRAIN;
            end else begin
               rd_idx_in = rd_idx_ff + 1'b1;
            end
         end
         ST_DRAIN: begin
            if (drain_ff == DRAIN_LAST) begin
               if (!rsp_valid_ff || rsp_ready) begin
                  cmd.rsp_load = 1'b1;
                  rsp_valid_in = 1'b1;
                  state_in     = ST_IDLE;
               end
            end else begin
               drain_in = drain_ff + 1'b1;
            end
         end
         default: state_in = ST_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         vcount_ff    <= '0;
         rd_idx_ff    <= '0;
         drain_ff     <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         vcount_ff    <= vcount_in;
         rd_idx_ff    <= rd_idx_in;
         drain_ff     <= drain_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

`ifndef NO_ASSERTIONS
   a_vcount_bound: assert property (@(posedge clock) disable iff (reset)
      vcount_ff <= CW'(MAX_VERTICES))
      else $error("vertex count exceeds store size");

   a_load_no_overwrite: assert property (@(posedge clock) disable iff (reset)
      cmd.rsp_load |-> (!rsp_valid_ff || rsp_ready))
      else $error("response loaded over a pending response");

   a_write_advances: assert property (@(posedge clock) disable iff (reset)
      cmd.wr_en |=> (vcount_ff == CW'($past(wr_addr)) + 1'b1))
      else $error("vertex count does not follow write address");

   a_query_setup: assert property (@(posedge clock) disable iff (reset)
      cmd.query_start |=> cmd.setup)
      else $error("query start not followed by setup");
`endif

endmodule

// ----- hdl/prt_dpath.sv -----
// ----------------------------------------------------------------------------
// prt_dpath
// Vertex store, rightmost vertex tracking and the pipelined edge test with
// its crossing accumulator.
// ----------------------------------------------------------------------------
module prt_dpath #(
   parameter  int MAX_VERTICES = 64,
   localparam int AW = $clog2(MAX_VERTICES),
   localparam int CW = $clog2(MAX_VERTICES + 1)
) (
   input  logic                  clock,
   input  logic                  reset,
   input  prt_pkg::prt_req_type  req_data,
   input  prt_pkg::prt_cmd_type  cmd,
   input  logic [AW-1:0]         wr_addr,
   input  logic [AW-1:0]         rd_addr,
   output prt_pkg::prt_rsp_type  rsp_data
);
   import prt_pkg::*;

   localparam int SW = CW + COUNT_W;

   prt_vtx_type                mem_ff [MAX_VERTICES];
   prt_vtx_type                rd_data_ff;
   prt_vtx_type                prev_ff;
   prt_vtx_type                rm_ff;
   logic signed [COORD_W-1:0]  ax_ff, ay_ff, by_ff;
   logic signed [BX_W-1:0]     bx_ff, bx_in;
   logic                       first_only_ff;
   logic signed [DIFF_W-1:0]   ux_ff, uy_ff;
   logic signed [DIFF_W-1:0]   p0x_ff, p0y_ff, p1x_ff, p1y_ff;
   logic signed [DIFF_W-1:0]   wx_ff, wy_ff, qbx_ff, qby_ff;
   logic signed [PROD_W-1:0]   m1a_ff, m1b_ff, m2a_ff, m2b_ff;
   logic signed [PROD_W-1:0]   m3a_ff, m3b_ff, m4a_ff, m4b_ff;
   logic signed [ORIENT_W-1:0] o1, o2, o3, o4;
   logic                       rd_vld_ff, rd_edge_ff, d_vld_ff, m_vld_ff, x_vld_ff;
   logic                       x_hit_ff;
   logic [CW-1:0]              acc_ff;
   logic [SW-1:0]              acc_wide;
   logic [COUNT_W-1:0]         count_sat;
   prt_rsp_type                rsp_ff;

   assign bx_in = cmd.query_inside ? (BX_W'(rm_ff.x) + BX_W'(FRAC_ONE))
                                   : BX_W'(req_data.x1);

   assign o1 = ORIENT_W'(m1a_ff) - ORIENT_W'(m1b_ff);
   assign o2 = ORIENT_W'(m2a_ff) - ORIENT_W'(m2b_ff);
   assign o3 = ORIENT_W'(m3b_ff) - ORIENT_W'(m3a_ff);
   assign o4 = ORIENT_W'(m4a_ff) - ORIENT_W'(m4b_ff);

   assign acc_wide  = SW'(acc_ff);
   assign count_sat = (acc_wide > SW'(COUNT_MAX)) ? COUNT_W'(COUNT_MAX)
                                                  : acc_wide[COUNT_W-1:0];
   assign rsp_data  = rsp_ff;

   always_ff @(posedge clock) begin
      if (cmd.wr_en) begin
         mem_ff[wr_addr] <= '{x: req_data.x0, y: req_data.y0};
      end
      if (cmd.rd_en) begin
         rd_data_ff <= mem_ff[rd_addr];
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.wr_en && (cmd.wr_first || (req_data.x0 > rm_ff.x))) begin
         rm_ff <= '{x: req_data.x0, y: req_data.y0};
      end
      if (cmd.query_start) begin
         ax_ff         <= req_data.x0;
         ay_ff         <= req_data.y0;
         bx_ff         <= bx_in;
         by_ff         <= cmd.query_inside ? rm_ff.y : req_data.y1;
         first_only_ff <= !cmd.query_inside && req_data.stop_at_first;
      end
      if (cmd.setup) begin
         ux_ff <= DIFF_W'(bx_ff) - DIFF_W'(ax_ff);
         uy_ff <= DIFF_W'(by_ff) - DIFF_W'(ay_ff);
      end
      if (rd_vld_ff) begin
         prev_ff <= rd_data_ff;
      end
      p0x_ff <= DIFF_W'(prev_ff.x) - DIFF_W'(ax_ff);
      p0y_ff <= DIFF_W'(prev_ff.y) - DIFF_W'(ay_ff);
      p1x_ff <= DIFF_W'(rd_data_ff.x) - DIFF_W'(ax_ff);
      p1y_ff <= DIFF_W'(rd_data_ff.y) - DIFF_W'(ay_ff);
      wx_ff  <= DIFF_W'(rd_data_ff.x) - DIFF_W'(prev_ff.x);
      wy_ff  <= DIFF_W'(rd_data_ff.y) - DIFF_W'(prev_ff.y);
      qbx_ff <= DIFF_W'(bx_ff) - DIFF_W'(prev_ff.x);
      qby_ff <= DIFF_W'(by_ff) - DIFF_W'(prev_ff.y);
      m1a_ff <= PROD_W'(p0x_ff) * PROD_W'(uy_ff);
      m1b_ff <= PROD_W'(p0y_ff) * PROD_W'(ux_ff);
      m2a_ff <= PROD_W'(p1x_ff) * PROD_W'(uy_ff);
      m2b_ff <= PROD_W'(p1y_ff) * PROD_W'(ux_ff);
      m3a_ff <= PROD_W'(p0x_ff) * PROD_W'(wy_ff);
      m3b_ff <= PROD_W'(p0y_ff) * PROD_W'(wx_ff);
      m4a_ff <= PROD_W'(qbx_ff) * PROD_W'(wy_ff);
      m4b_ff <= PROD_W'(qby_ff) * PROD_W'(wx_ff);
      x_hit_ff <= prt_opposite(o1, o2) && prt_opposite(o3, o4);
      if (cmd.query_start) begin
         acc_ff <= '0;
      end else if (x_vld_ff && x_hit_ff && !(first_only_ff && (acc_ff != '0))) begin
         acc_ff <= acc_ff + 1'b1;
      end
      if (cmd.rsp_load) begin
         rsp_ff <= '{crossing_count: count_sat, inside_res: acc_ff[0]};
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rd_vld_ff  <= 1'b0;
         rd_edge_ff <= 1'b0;
         d_vld_ff   <= 1'b0;
         m_vld_ff   <= 1'b0;
         x_vld_ff   <= 1'b0;
      end else begin
         rd_vld_ff  <= cmd.rd_en;
         rd_edge_ff <= cmd.rd_en && !cmd.rd_first;
         d_vld_ff   <= rd_edge_ff;
         m_vld_ff   <= d_vld_ff;
         x_vld_ff   <= m_vld_ff;
      end
   end

endmodule

// ----- hdl/polygon_ray_crossing_tester.sv -----
// ----------------------------------------------------------------------------
// polygon_ray_crossing_tester
// Stores one closed polygon and answers segment crossing and point inside
// requests by walking its edges through a cross-product pipeline.
// ----------------------------------------------------------------------------
// Load request: accepted while idle; the next request may follow the cycle after.
// Query request: accepted while idle; setup, edge walk over the N stored vertices,
//   drain, then the response; no new request is taken until the query completes.
// The edge walk reads one vertex per cycle from the single store read port.
// Reset clears the vertex count and control; the vertex store is not cleared.
module polygon_ray_crossing_tester #(
   parameter int MAX_VERTICES = 64
) (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  req_valid,
   output logic                  req_ready,
   input  prt_pkg::prt_req_type  req_data,
   output logic                  rsp_valid,
   input  logic                  rsp_ready,
   output prt_pkg::prt_rsp_type  rsp_data
);
   import prt_pkg::*;

   localparam int AW = $clog2(MAX_VERTICES);

   prt_cmd_type    cmd;
   logic [AW-1:0]  wr_addr;
   logic [AW-1:0]  rd_addr;

   prt_ctrl #(
      .MAX_VERTICES (MAX_VERTICES)
   ) u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_ready (req_ready),
      .req_data  (req_data),
      .rsp_valid (rsp_valid),
      .rsp_ready (rsp_ready),
      .cmd       (cmd),
      .wr_addr   (wr_addr),
      .rd_addr   (rd_addr)
   );

   prt_dpath #(
      .MAX_VERTICES (MAX_VERTICES)
   ) u_dpath (
      .clock    (clock),
      .reset    (reset),
      .req_data (req_data),
      .cmd      (cmd),
      .wr_addr  (wr_addr),
      .rd_addr  (rd_addr),
      .rsp_data (rsp_data)
   );

endmodule
